// ----- src/gbpf_pkg.sv -----
// Shared types and constants of the prime-factorization GCD core.
package gbpf_pkg;

  localparam int unsigned FIRST_TRIAL = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SIDE,
    ST_WAIT,
    ST_UPDATE,
    ST_MUL,
    ST_STEP,
    ST_FINAL,
    ST_DONE
  } gbpf_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- src/gcd_by_prime_factorization_core.sv -----
// Top level of the GCD core: factors both operands by trial division and merges the primes.
//
// Both operands are factored together by trial divisors d = 2, 3, 4, ... An operand drops
// out of the trials once d*d exceeds what is left of it, and its leftover above one counts
// as a single prime. For every d that divides both operands the running product is
// multiplied by d to the smaller exponent, and a common leftover prime is multiplied in at
// the end. All divisions go through one shared restoring divider; a transfer runs one
// division per active operand for each trial divisor up to the square root of the larger
// operand, one more per extracted prime factor, and one pass of the multiply state per
// multiplication. The core takes one transfer at a time, and a finished result is held
// in an output register while the next transfer is accepted.
module gcd_by_prime_factorization_core #(
  parameter int unsigned VALUE_WIDTH  = 16,
  parameter int unsigned FACTOR_SLOTS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] first_value_i,
  input  logic [VALUE_WIDTH-1:0] second_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [VALUE_WIDTH-1:0] gcd_value_o
);
  import gbpf_pkg::*;

  localparam int unsigned ExpW = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned CntW = $clog2(FACTOR_SLOTS + 1);
  localparam int unsigned SqW  = VALUE_WIDTH + 1;
  localparam logic [CntW-1:0] Slots = CntW'(FACTOR_SLOTS);

  gbpf_state_e            state_q, state_d;
  logic [VALUE_WIDTH-1:0] rest_a_q, rest_a_d, rest_b_q, rest_b_d;
  logic                   act_a_q, act_a_d, act_b_q, act_b_d;
  logic                   in_a_q, in_a_d, in_b_q, in_b_d;
  logic [CntW-1:0]        cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [ExpW-1:0]        exp_a_q, exp_a_d, exp_b_q, exp_b_d;
  logic [VALUE_WIDTH-1:0] d_q, d_d;
  logic [SqW-1:0]         sq_q, sq_d;
  logic                   side_q, side_d;
  logic [VALUE_WIDTH-1:0] prod_q, prod_d;
  logic [VALUE_WIDTH-1:0] mul_op_q, mul_op_d;
  logic [ExpW-1:0]        mul_cnt_q, mul_cnt_d;
  logic                   mul_fin_q, mul_fin_d;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] gcd_q, gcd_d;

  logic [2*VALUE_WIDTH-1:0] mul_full;
  logic                     chk_a, chk_b;
  logic                     cur_act;
  logic [VALUE_WIDTH-1:0]   cur_rest;
  logic                     list_a, list_b;
  logic [ExpW-1:0]          eff_a, eff_b;
  logic                     div_start;
  logic [VALUE_WIDTH-1:0]   div_quo, div_rem;
  div_status_t              div_stat;

  gbpf_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (cur_rest),
    .divisor_i   (d_q),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .status_o    (div_stat)
  );

  assign mul_full = prod_q * mul_op_q;

  always_comb begin
    chk_a    = act_a_q && (sq_q <= {1'b0, rest_a_q});
    chk_b    = act_b_q && (sq_q <= {1'b0, rest_b_q});
    cur_act  = side_q ? act_b_q : act_a_q;
    cur_rest = side_q ? rest_b_q : rest_a_q;
    list_a   = act_a_q ? ((exp_a_q != '0) && (cnt_a_q < Slots))
                       : (in_a_q && (rest_a_q == d_q));
    list_b   = act_b_q ? ((exp_b_q != '0) && (cnt_b_q < Slots))
                       : (in_b_q && (rest_b_q == d_q));
    eff_a    = act_a_q ? exp_a_q : ExpW'(1);
    eff_b    = act_b_q ? exp_b_q : ExpW'(1);

    state_d     = state_q;
    rest_a_d    = rest_a_q;
    rest_b_d    = rest_b_q;
    act_a_d     = act_a_q;
    act_b_d     = act_b_q;
    in_a_d      = in_a_q;
    in_b_d      = in_b_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    exp_a_d     = exp_a_q;
    exp_b_d     = exp_b_q;
    d_d         = d_q;
    sq_d        = sq_q;
    side_d      = side_q;
    prod_d      = prod_q;
    mul_op_d    = mul_op_q;
    mul_cnt_d   = mul_cnt_q;
    mul_fin_d   = mul_fin_q;
    gcd_d       = gcd_q;
    out_valid_d = out_valid_q;
    div_start   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rest_a_d = first_value_i;
          rest_b_d = second_value_i;
          act_a_d  = 1'b1;
          act_b_d  = 1'b1;
          cnt_a_d  = '0;
          cnt_b_d  = '0;
          d_d      = VALUE_WIDTH'(FIRST_TRIAL);
          sq_d     = SqW'(FIRST_TRIAL * FIRST_TRIAL);
          prod_d   = VALUE_WIDTH'(1);
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        act_a_d = chk_a;
        act_b_d = chk_b;
        if (act_a_q && !chk_a) begin
          in_a_d = cnt_a_q < Slots;
        end
        if (act_b_q && !chk_b) begin
          in_b_d = cnt_b_q < Slots;
        end
        if (!chk_a && !chk_b) begin
          state_d = ST_FINAL;
        end else begin
          side_d  = 1'b0;
          exp_a_d = '0;
          exp_b_d = '0;
          state_d = ST_SIDE;
        end
      end
      ST_SIDE: begin
        if (cur_act) begin
          div_start = 1'b1;
          state_d   = ST_WAIT;
        end else if (!side_q) begin
          side_d = 1'b1;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          if (div_rem == '0) begin
            if (side_q) begin
              rest_b_d = div_quo;
              exp_b_d  = exp_b_q + ExpW'(1);
            end else begin
              rest_a_d = div_quo;
              exp_a_d  = exp_a_q + ExpW'(1);
            end
            state_d = ST_SIDE;
          end else if (!side_q) begin
            side_d  = 1'b1;
            state_d = ST_SIDE;
          end else begin
            state_d = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        if (act_a_q && (exp_a_q != '0) && (cnt_a_q < Slots)) begin
          cnt_a_d = cnt_a_q + CntW'(1);
        end
        if (act_b_q && (exp_b_q != '0) && (cnt_b_q < Slots)) begin
          cnt_b_d = cnt_b_q + CntW'(1);
        end
        if (list_a && list_b) begin
          mul_op_d  = d_q;
          mul_cnt_d = (eff_a < eff_b) ? eff_a : eff_b;
          mul_fin_d = 1'b0;
          state_d   = ST_MUL;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_MUL: begin
        prod_d    = mul_full[VALUE_WIDTH-1:0];
        mul_cnt_d = mul_cnt_q - ExpW'(1);
        if (mul_cnt_q == ExpW'(1)) begin
          state_d = mul_fin_q ? ST_DONE : ST_STEP;
        end
      end
      ST_STEP: begin
        d_d     = d_q + VALUE_WIDTH'(1);
        sq_d    = sq_q + {d_q, 1'b1};
        state_d = ST_CHECK;
      end
      ST_FINAL: begin
        if (in_a_q && in_b_q && (rest_a_q > VALUE_WIDTH'(1)) && (rest_a_q == rest_b_q)) begin
          mul_op_d  = rest_a_q;
          mul_cnt_d = ExpW'(1);
          mul_fin_d = 1'b1;
          state_d   = ST_MUL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          gcd_d       = prod_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_a_q  <= rest_a_d;
    rest_b_q  <= rest_b_d;
    act_a_q   <= act_a_d;
    act_b_q   <= act_b_d;
    in_a_q    <= in_a_d;
    in_b_q    <= in_b_d;
    cnt_a_q   <= cnt_a_d;
    cnt_b_q   <= cnt_b_d;
    exp_a_q   <= exp_a_d;
    exp_b_q   <= exp_b_d;
    d_q       <= d_d;
    sq_q      <= sq_d;
    side_q    <= side_d;
    prod_q    <= prod_d;
    mul_op_q  <= mul_op_d;
    mul_cnt_q <= mul_cnt_d;
    mul_fin_q <= mul_fin_d;
    gcd_q     <= gcd_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign gcd_value_o = gcd_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (prod_q != '0))
    else $error("Running product became zero.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (mul_cnt_q != '0))
    else $error("Multiply state entered with no multiplications left.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) && !div_stat.done |-> div_stat.busy)
    else $error("Waiting on a divider that is not running.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> (state_q == ST_CHECK))
    else $error("Accepted transfer did not start the trial loop.");

endmodule

// ----- src/gbpf_divider.sv -----
// Iterative restoring divider that produces one quotient bit per cycle.
module gbpf_divider #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [VALUE_WIDTH-1:0]  dividend_i,
  input  logic [VALUE_WIDTH-1:0]  divisor_i,
  output logic [VALUE_WIDTH-1:0]  quotient_o,
  output logic [VALUE_WIDTH-1:0]  remainder_o,
  output gbpf_pkg::div_status_t   status_o
);
  import gbpf_pkg::*;

  localparam int unsigned CntW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] div_q, div_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   ge;

  always_comb begin
    trial  = {rem_q, quo_q[VALUE_WIDTH-1]};
    diff   = trial - {1'b0, div_q};
    ge     = trial >= {1'b0, div_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CntW'(VALUE_WIDTH - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      quo_d = {quo_q[VALUE_WIDTH-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (div_q != '0) |-> rem_q < div_q)
    else $error("Divider remainder is not below the divisor.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("Divider reports done while still busy.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> cnt_q == CntW'(VALUE_WIDTH - 1))
    else $error("Divider started without a full bit count.");

endmodule
